// File: rtl/core/rmc_pkg.sv
// Shared types and constants for the region mean color block.
`timescale 1ns / 1ps
package rmc_pkg;
	localparam int SUM_BITS = 32;
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_PAINT = 1'b1;
	localparam logic [0:0] REG_LABEL_OFFSET = 1'b0;
	localparam logic [0:0] REG_COLOR_MODE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic        bad;
		logic [15:0] index;
		logic [7:0]  luma;
		logic [7:0]  blue;
		logic [7:0]  red;
		logic        color;
	} rmc_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_DIVIDE, ST_OUT
	} rmc_state_t;
endpackage

// File: rtl/core/rmc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// File: rtl/core/rmc_front.sv
// Front end: classify requests and hold them in a short queue.
`timescale 1ns / 1ps
module rmc_front #(
	parameter int LABEL_COUNT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [40:0]       in_data,
	input  logic [15:0]       label_offset,
	input  logic              color_mode,
	output logic              q_valid,
	input  logic              q_ready,
	output rmc_pkg::rmc_req_t q_req
);
	import rmc_pkg::*;
	localparam int DEPTH = 2;
	rmc_req_t  slot_q [DEPTH];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [16:0] diff;
	rmc_req_t  req;
	logic      push, pop;

	assign diff = {1'b0, in_data[16:1]} - {1'b0, label_offset};
	always_comb begin
		req.opcode = in_data[0];
		req.bad    = diff[16] || (diff[15:0] >= 17'(LABEL_COUNT));
		req.index  = diff[15:0];
		req.luma   = in_data[24:17];
		req.blue   = in_data[32:25];
		req.red    = in_data[40:33];
		req.color  = color_mode;
	end
	assign in_ready = cnt_q != 2'(DEPTH);
	assign q_valid  = cnt_q != 2'd0;
	assign q_req    = slot_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk) if (push) slot_q[wp_q] <= req;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
endmodule

// File: rtl/core/rmc_back.sv
// Back end: read-modify-write of label stores and serial mean division.
`timescale 1ns / 1ps
module rmc_back #(
	parameter int LABEL_COUNT = 4096,
	parameter int COUNT_BITS  = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  rmc_pkg::rmc_req_t q_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [24:0]       out_data
);
	import rmc_pkg::*;
	localparam int AW = $clog2(LABEL_COUNT);
	localparam int ENT = COUNT_BITS + 3 * SUM_BITS;

	rmc_state_t state_q, state_d;
	rmc_req_t   req_q;
	logic [AW:0] clr_q;
	logic [5:0] bit_q;
	logic [ENT-1:0] rdata, wdata;
	logic        we;
	logic [AW-1:0] addr;
	logic [COUNT_BITS-1:0] cnt;
	logic [SUM_BITS-1:0] ys, bs, rs;
	logic [SUM_BITS-1:0] qy_q, qb_q, qr_q;
	logic [COUNT_BITS:0] ry_q, rb_q, rr_q;
	logic [COUNT_BITS:0] ty, tb, tr;
	logic [24:0] res_q;

	rmc_ram #(.WIDTH(ENT), .DEPTH(LABEL_COUNT)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	assign {cnt, ys, bs, rs} = rdata;

	function automatic logic [SUM_BITS-1:0] sat(input logic [SUM_BITS-1:0] a,
			input logic [7:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + (SUM_BITS+1)'(b);
		return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
	endfunction

	function automatic logic [7:0] clamp(input logic [SUM_BITS-1:0] q);
		return (q > 32'd255) ? 8'hFF : q[7:0];
	endfunction

	always_comb begin
		ty = {ry_q[COUNT_BITS-1:0], qy_q[SUM_BITS-1]};
		tb = {rb_q[COUNT_BITS-1:0], qb_q[SUM_BITS-1]};
		tr = {rr_q[COUNT_BITS-1:0], qr_q[SUM_BITS-1]};
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		we = 1'b0;
		addr = req_q.index[AW-1:0];
		wdata = {cnt + COUNT_BITS'(1), sat(ys, req_q.luma),
			req_q.color ? sat(bs, req_q.blue) : bs,
			req_q.color ? sat(rs, req_q.red) : rs};
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1; addr = clr_q[AW-1:0]; wdata = '0;
				if (clr_q == (AW+1)'(LABEL_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				q_ready = 1'b1;
				addr = q_req.index[AW-1:0];
				if (q_valid) begin
					if (q_req.bad) state_d = (q_req.opcode == OP_PAINT) ? ST_OUT : ST_IDLE;
					else state_d = ST_READ;
				end
			end
			ST_READ: state_d = (req_q.opcode == OP_PAINT) ? ST_DIVIDE : ST_UPDATE;
			ST_UPDATE: begin
				we = cnt != '1;
				state_d = ST_IDLE;
			end
			ST_DIVIDE: if (bit_q == 6'd0) state_d = ST_OUT;
			ST_OUT: if (out_valid && out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// restoring division, one quotient bit per cycle for all three channels
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			req_q <= q_req;
			res_q <= {1'b1, 24'd0};
		end
		if (state_q == ST_READ) begin
			qy_q <= ys; qb_q <= bs; qr_q <= rs;
			ry_q <= '0; rb_q <= '0; rr_q <= '0;
			bit_q <= 6'(SUM_BITS - 1);
		end
		if (state_q == ST_DIVIDE) begin
			bit_q <= bit_q - 6'd1;
			if (ty >= {1'b0, cnt}) begin
				ry_q <= ty - {1'b0, cnt}; qy_q <= {qy_q[SUM_BITS-2:0], 1'b1};
			end else begin
				ry_q <= ty; qy_q <= {qy_q[SUM_BITS-2:0], 1'b0};
			end
			if (tb >= {1'b0, cnt}) begin
				rb_q <= tb - {1'b0, cnt}; qb_q <= {qb_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rb_q <= tb; qb_q <= {qb_q[SUM_BITS-2:0], 1'b0};
			end
			if (tr >= {1'b0, cnt}) begin
				rr_q <= tr - {1'b0, cnt}; qr_q <= {qr_q[SUM_BITS-2:0], 1'b1};
			end else begin
				rr_q <= tr; qr_q <= {qr_q[SUM_BITS-2:0], 1'b0};
			end
		end
		if (state_q == ST_DIVIDE && bit_q == 6'd0) begin
			res_q <= '0;
		end
		if (state_q == ST_OUT && res_q[24] == 1'b0 && cnt != '0 && bit_q == 6'h3F) begin
			res_q <= {1'b0, req_q.color ? clamp(qr_q) : 8'd0,
				req_q.color ? clamp(qb_q) : 8'd0, clamp(qy_q)};
			bit_q <= 6'h3E;
		end
	end

	// quotients are in their registers after the last step; latch them on entry to output
	assign out_valid = (state_q == ST_OUT) && (res_q[24] || cnt == '0 || bit_q == 6'h3E);
	assign out_data = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE)) else $error("stray write");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == ST_IDLE) else $error("accept while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// File: rtl/core/region_mean_color.sv
// Top level of the region mean color block.
`timescale 1ns / 1ps
// region_mean_color: per-label pixel sums and truncated mean paint.
// Slave channel s_axis carries requests: tdata = {cr, cb, luma, label},
// tuser = opcode (0 accumulate, 1 paint). Master m_axis carries one result
// per paint request: tdata = {bad_label, mean_red, mean_blue, mean_luma}.
// Configuration: cfg_we writes label_offset (index 0) or color_mode (index 1);
// write only while idle.
// After reset the back end sweeps the label store, one entry a cycle, over
// all LABEL_COUNT entries; requests queue in the front but are not executed.
// An accumulate steps through read, modify-write and idle; a paint steps
// through read, the restoring divide at one quotient bit per cycle, run in
// parallel for the three channels, and output. An out-of-range label skips
// the store: an accumulate is dropped and a paint goes straight to output.
// With an idle back end, m_axis_tvalid rises for a paint after the divide
// and a result latch; a label with no pixels skips the latch (zero means).
// A two-entry request queue decouples the input from the back end. When the
// receiver stalls, the result holds on m_axis_tdata and the back end waits;
// the queue keeps accepting until full.
module region_mean_color #(
	parameter int LABEL_COUNT = 4096,
	parameter int COUNT_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // label[15:0], luma, chroma_blue, chroma_red
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // mean_luma, mean_blue, mean_red, bad_label, pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import rmc_pkg::*;
	logic [15:0] label_offset_q;
	logic        color_mode_q;
	logic        q_valid, q_ready;
	rmc_req_t    q_req;
	logic [24:0] res;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_offset_q <= '0; color_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LABEL_OFFSET: label_offset_q <= cfg_data;
				REG_COLOR_MODE:   color_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rmc_front #(.LABEL_COUNT(LABEL_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data({s_axis_tdata, s_axis_tuser}), .label_offset(label_offset_q),
		.color_mode(color_mode_q), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

	rmc_back #(.LABEL_COUNT(LABEL_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res));

	assign m_axis_tdata = {7'd0, res};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[24]) |-> m_axis_tdata[23:0] == 24'd0)
		else $error("bad label with nonzero means");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !color_mode_q) |-> m_axis_tdata[23:8] == 16'd0)
		else $error("chroma painted in gray mode");
endmodule
